// ----- hdl/llta_pkg.sv -----
// ----------------------------------------------------------------------------
// llta_pkg: shared types and constants of the least-loaded task assigner
// Holds default sizes, the fixed port field widths, the sequencer state type
// and the control bundle that drives the scan unit.
// ----------------------------------------------------------------------------
package llta_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int LLTA_NUM_RESOURCES = 16;
   localparam int LLTA_DIFF_WIDTH    = 16;
   localparam int LLTA_LOAD_WIDTH    = 32;

   // Fixed field widths on the ports.
   localparam int REQ_DIFF_BITS   = 16;
   localparam int REQ_TDATA_BITS  = 24;
   localparam int RSP_INDEX_BITS  = 4;
   localparam int RSP_LOAD_BITS   = 32;
   localparam int RSP_TDATA_BITS  = 72;
   localparam int CSR_BITS        = 5;
   localparam logic [CSR_BITS-1:0] CSR_RESET_VALUE = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic sample;   // a load word is present at the scan input
      logic first;    // it is the word of resource zero: restart the search
   } scan_ctl_type;

endpackage

// ----- hdl/least_loaded_task_assigner_core.sv -----
// ----------------------------------------------------------------------------
// least_loaded_task_assigner_core: greedy least-loaded task assignment
// Adds each task's difficulty to the active resource with the smallest load,
// then reports the chosen index, its new load and the load spread.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  req_*     in         req_tvalid/req_tready  start_batch, difficulty
//  rsp_*     out        rsp_tvalid/rsp_tready  index, new load, spread; saturated
//  csr_*     in         csr_wr_en              active_resources
//
//  After acceptance a request passes through a scan, a drain state, an add
//  state and a finish state before its response is ready to leave. The scan
//  reads one load word per cycle from the load RAM through its single read
//  port, one for each of the effective number of active resources. The next
//  request can be accepted the cycle after the write-back. Reset is synchronous
//  and immediate (no clearing pass). The finish cycle stalls only while a
//  previous response still sits unaccepted in the output register.
//
module least_loaded_task_assigner_core
   import llta_pkg::*;
#(
   parameter int NUM_RESOURCES = LLTA_NUM_RESOURCES,
   parameter int DIFF_WIDTH    = LLTA_DIFF_WIDTH,
   parameter int LOAD_WIDTH    = LLTA_LOAD_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata, from bit 0: start_batch[0], difficulty[16:1], zero pad[23:17]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // rsp_tdata, from bit 0: resource_index[3:0], new_load[35:4],
   // load_spread[67:36], zero pad[71:68]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // rsp_tuser, from bit 0: saturated[0]
   output logic                      rsp_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_wr_en,
   input  logic [CSR_BITS-1:0]       csr_wr_data
);

   // Index width for resources, and a width wide enough to compare the
   // active-resource register against the resource count.
   localparam int IW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int CW  = $clog2(NUM_RESOURCES + 1);
   localparam int KW  = (CW > CSR_BITS) ? CW : CSR_BITS;
   // Difficulty bits that survive the DIFF_WIDTH mask.
   localparam int DK  = (DIFF_WIDTH < REQ_DIFF_BITS) ? DIFF_WIDTH : REQ_DIFF_BITS;
   localparam logic [REQ_DIFF_BITS-1:0] DiffMask =
      REQ_DIFF_BITS'((17'(1) << DK) - 17'(1));
   // Sum width: room for the carry past LOAD_WIDTH even when the difficulty
   // is wider than a load.
   localparam int SW  = ((LOAD_WIDTH > REQ_DIFF_BITS) ? LOAD_WIDTH : REQ_DIFF_BITS) + 1;
   // Widths used to fit internal values into the fixed response fields.
   localparam int XW  = (LOAD_WIDTH > RSP_LOAD_BITS) ? LOAD_WIDTH : RSP_LOAD_BITS;
   localparam int PW  = (IW > RSP_INDEX_BITS) ? IW : RSP_INDEX_BITS;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                  state_ff, state_in;
   logic [CSR_BITS-1:0]        csr_ff;
   logic [REQ_DIFF_BITS-1:0]   diff_ff;
   logic [IW-1:0]              last_ff;
   logic [IW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                       samp_ff;
   logic [IW-1:0]              samp_idx_ff;
   logic                       samp_ok_ff;
   // One valid bit per load entry; an entry not valid reads as zero load.
   // Reset and start_batch clear all of them at once.
   logic [NUM_RESOURCES-1:0]   valid_ff;
   logic [LOAD_WIDTH-1:0]      sum_ff;
   logic                       sat_ff;
   logic                       rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0]  rsp_data_ff;
   logic                       rsp_user_ff;

   // ---------------------------------------------------------------------
   // Combinational signals
   // ---------------------------------------------------------------------
   logic                       req_accept;
   logic                       rd_en;
   logic                       finish;
   logic [IW-1:0]              last_idx;
   logic [KW-1:0]              cnt;
   logic [LOAD_WIDTH-1:0]      ram_rdata;
   logic [LOAD_WIDTH-1:0]      samp_load;
   scan_ctl_type               scan_ctl;
   logic [LOAD_WIDTH-1:0]      min_load;
   logic [IW-1:0]              min_idx;
   logic [LOAD_WIDTH-1:0]      next_load;
   logic                       next_ok;
   logic [LOAD_WIDTH-1:0]      max_load;
   logic [SW-1:0]              sum_wide;
   logic [LOAD_WIDTH-1:0]      hi_load;
   logic [LOAD_WIDTH-1:0]      lo_load;
   logic [LOAD_WIDTH-1:0]      spread;
   logic [XW-1:0]              sum_x;
   logic [XW-1:0]              spread_x;
   logic [PW-1:0]              idx_pad;

   assign req_accept = req_tvalid && req_tready;

   // Effective active count: zero behaves as one, anything above the
   // resource count behaves as the resource count. Kept as the last index.
   always_comb begin
      cnt = KW'(csr_ff);
      if (cnt == '0) begin
         last_idx = '0;
      end else if (cnt > KW'(NUM_RESOURCES)) begin
         last_idx = IW'(NUM_RESOURCES - 1);
      end else begin
         last_idx = IW'(cnt - KW'(1));
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state and strobes
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      rd_ptr_in  = rd_ptr_ff;
      req_tready = 1'b0;
      rd_en      = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rd_ptr_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (rd_ptr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_ptr_in = rd_ptr_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            // The last load word reaches the scan unit in this cycle.
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Write back and hand over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Load store and scan
   // ---------------------------------------------------------------------
   llta_ram #(
      .WIDTH (LOAD_WIDTH),
      .DEPTH (NUM_RESOURCES)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (min_idx),
      .wr_data (sum_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // The valid bit is sampled with the read so that a cleared entry
   // contributes a zero load.
   assign samp_load      = samp_ok_ff ? ram_rdata : '0;
   assign scan_ctl.sample = samp_ff;
   assign scan_ctl.first  = (samp_idx_ff == '0);

   llta_scan #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .LOAD_WIDTH    (LOAD_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .samp_load (samp_load),
      .samp_idx  (samp_idx_ff),
      .min_load  (min_load),
      .min_idx   (min_idx),
      .next_load (next_load),
      .next_ok   (next_ok),
      .max_load  (max_load)
   );

   // ---------------------------------------------------------------------
   // Saturating add and spread
   // ---------------------------------------------------------------------
   // Any carry above LOAD_WIDTH means the load clips at all ones. A load
   // already at its maximum with a nonzero difficulty is caught by this too.
   assign sum_wide = SW'(min_load) + SW'(diff_ff & DiffMask);

   // After the update the largest load is the old maximum or the new sum,
   // and the smallest is the new sum or the smallest of the other resources.
   // With a single active resource both are the sum and the spread is zero.
   always_comb begin
      hi_load = (sum_ff > max_load) ? sum_ff : max_load;
      lo_load = (next_ok && (next_load < sum_ff)) ? next_load : sum_ff;
      spread  = hi_load - lo_load;
      sum_x    = XW'(sum_ff);
      spread_x = XW'(spread);
      idx_pad  = PW'(min_idx);
   end

   // ---------------------------------------------------------------------
   // Clocked state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_RESET_VALUE;
         valid_ff     <= '0;
         samp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         samp_ff  <= rd_en;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (req_accept && req_tdata[0]) begin
            valid_ff <= '0;
         end else if (finish) begin
            valid_ff[min_idx] <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      rd_ptr_ff <= rd_ptr_in;
      if (req_accept) begin
         diff_ff <= req_tdata[REQ_DIFF_BITS:1];
         last_ff <= last_idx;
      end
      samp_idx_ff <= rd_ptr_ff;
      samp_ok_ff  <= valid_ff[rd_ptr_ff];
      if (state_ff == ST_ADD) begin
         sum_ff <= (sum_wide[SW-1:LOAD_WIDTH] != '0) ? '1 : sum_wide[LOAD_WIDTH-1:0];
         sat_ff <= (sum_wide[SW-1:LOAD_WIDTH] != '0);
      end
      if (finish) begin
         rsp_data_ff <= {4'b0000, spread_x[RSP_LOAD_BITS-1:0], sum_x[RSP_LOAD_BITS-1:0],
                         idx_pad[RSP_INDEX_BITS-1:0]};
         rsp_user_ff <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- hdl/llta_ram.sv -----
// ----------------------------------------------------------------------------
// llta_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module llta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/llta_scan.sv -----
// ----------------------------------------------------------------------------
// llta_scan: running minimum, runner-up and maximum over streamed loads
// Takes one load word per cycle in index order and keeps the lowest-index
// minimum, the smallest load among the other resources, and the maximum.
// ----------------------------------------------------------------------------
module llta_scan
   import llta_pkg::*;
#(
   parameter int NUM_RESOURCES = LLTA_NUM_RESOURCES,
   parameter int LOAD_WIDTH    = LLTA_LOAD_WIDTH,
   localparam int IW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctl_type          ctl,
   input  logic [LOAD_WIDTH-1:0] samp_load,
   input  logic [IW-1:0]         samp_idx,
   output logic [LOAD_WIDTH-1:0] min_load,
   output logic [IW-1:0]         min_idx,
   output logic [LOAD_WIDTH-1:0] next_load,
   output logic                  next_ok,
   output logic [LOAD_WIDTH-1:0] max_load
);

   logic [LOAD_WIDTH-1:0] min_ff, min_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [LOAD_WIDTH-1:0] next_ff, next_in;
   logic                  next_ok_ff, next_ok_in;
   logic [LOAD_WIDTH-1:0] max_ff, max_in;

   always_comb begin
      min_in     = min_ff;
      idx_in     = idx_ff;
      next_in    = next_ff;
      next_ok_in = next_ok_ff;
      max_in     = max_ff;
      if (ctl.sample) begin
         if (ctl.first) begin
            min_in     = samp_load;
            idx_in     = samp_idx;
            max_in     = samp_load;
            next_ok_in = 1'b0;
         end else begin
            // A strictly smaller load takes over, so ties keep the lower index.
            if (samp_load < min_ff) begin
               min_in     = samp_load;
               idx_in     = samp_idx;
               next_in    = min_ff;
               next_ok_in = 1'b1;
            end else if (!next_ok_ff || (samp_load < next_ff)) begin
               next_in    = samp_load;
               next_ok_in = 1'b1;
            end
            if (samp_load > max_ff) begin
               max_in = samp_load;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ok_ff <= 1'b0;
      end else begin
         next_ok_ff <= next_ok_in;
      end
      min_ff  <= min_in;
      idx_ff  <= idx_in;
      next_ff <= next_in;
      max_ff  <= max_in;
   end

   assign min_load  = min_ff;
   assign min_idx   = idx_ff;
   assign next_load = next_ff;
   assign next_ok   = next_ok_ff;
   assign max_load  = max_ff;

endmodule
